// ----- hw/rtl/vra_pkg.sv -----
`timescale 1ns / 1ps

package vra_pkg;

  // Table geometry
  localparam int REGION_SLOTS = 512;
  localparam int PAGE_BYTES   = 4096;
  localparam int TABLE_DEPTH  = REGION_SLOTS - 1;
  localparam int IDX_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
  localparam logic [32:0]      PAGE_W    = 33'(PAGE_BYTES);
  localparam logic [32:0]      PAGE_M1   = 33'(PAGE_BYTES - 1);

  // Commands
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_CHECK   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] request_bytes;
    logic [31:0] query_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] alloc_start;
    logic        is_valid;
    logic [31:0] freed_start;
    logic [31:0] freed_bytes;
  } rsp_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } entry_t;

endpackage

// ----- hw/rtl/vra_ctrl.sv -----
`timescale 1ns / 1ps

module vra_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic [31:0]   pool_base,
  input  logic          req_fire,
  input  vra_pkg::req_t req,
  output logic          req_busy,
  output logic          res_valid,
  input  logic          res_take,
  output vra_pkg::rsp_t res
);
  import vra_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_AL_ROUND = 4'd1;
  localparam logic [3:0] S_AL_BASE  = 4'd2;
  localparam logic [3:0] S_AL_END   = 4'd3;
  localparam logic [3:0] S_AL_OVF   = 4'd4;
  localparam logic [3:0] S_CK_BASE  = 4'd5;
  localparam logic [3:0] S_SCAN     = 4'd6;
  localparam logic [3:0] S_SHIFT    = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0]       state;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] dst;
  logic             pend;
  logic [1:0]       cmd_q;
  logic [31:0]      req_q;
  logic [31:0]      addr_q;
  logic [32:0]      start_q;
  logic [32:0]      bytes_q;
  rsp_t             res_q;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;

  logic [32:0]      op_a;
  logic [32:0]      op_b;
  logic [33:0]      sum;
  logic [32:0]      rounded;
  logic [CNT_W-1:0] rd_addr;
  logic             wr_en;
  logic [CNT_W-1:0] wr_addr;
  entry_t           wr_entry;
  logic             base_hit;
  logic             range_hit;
  logic             eq_hit;

  // Shared adder: operands chosen by the sequencer step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_AL_ROUND: begin
        op_a = {1'b0, req_q};
        op_b = PAGE_M1;
      end
      S_AL_BASE, S_CK_BASE: begin
        op_a = {1'b0, pool_base};
        op_b = PAGE_W;
      end
      S_AL_END, S_SCAN: begin
        op_a = {1'b0, rd_q.start};
        op_b = {1'b0, rd_q.len};
      end
      S_AL_OVF: begin
        op_a = start_q;
        op_b = bytes_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    sum = {1'b0, op_a} + {1'b0, op_b};
  end

  // Round up to whole pages; the sequencer raises a zero result to one page
  assign rounded = sum[32:0] & ~PAGE_M1;

  // Compares against the adder output
  assign base_hit  = (addr_q >= pool_base) && ({2'b0, addr_q} < sum);
  assign range_hit = (addr_q >= rd_q.start) && ({2'b0, addr_q} < sum);
  assign eq_hit    = (rd_q.start == addr_q);

  // Table port steering
  always_comb begin
    rd_addr  = idx;
    wr_en    = 1'b0;
    wr_addr  = dst;
    wr_entry = rd_q;
    case (state)
      S_AL_ROUND: rd_addr = used - 1'b1;
      S_AL_OVF: begin
        wr_en    = (sum <= 34'h1_0000_0000);
        wr_addr  = used;
        wr_entry = '{start: start_q[31:0], len: bytes_q[31:0]};
      end
      S_SHIFT: begin
        wr_en = pend;
      end
      default: begin
        rd_addr = idx;
      end
    endcase
  end

  // Region table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[IDX_W-1:0]] <= wr_entry;
    end
    rd_q <= mem[rd_addr[IDX_W-1:0]];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            cmd_q  <= req.cmd;
            req_q  <= req.request_bytes;
            addr_q <= req.query_addr;
            res_q  <= '0;
            idx    <= '0;
            pend   <= 1'b0;
            case (req.cmd)
              CMD_ALLOC:   state <= S_AL_ROUND;
              CMD_RELEASE: state <= S_SCAN;
              CMD_CHECK:   state <= S_CK_BASE;
              default:     state <= S_DONE;
            endcase
          end
        end
        S_AL_ROUND: begin
          bytes_q <= (rounded == '0) ? PAGE_W : rounded;
          if (used >= DEPTH_CNT) begin
            res_q.status <= ST_FULL;
            state        <= S_DONE;
          end else if (used == '0) begin
            state <= S_AL_BASE;
          end else begin
            state <= S_AL_END;
          end
        end
        S_AL_BASE, S_AL_END: begin
          start_q <= sum[32:0];
          state   <= S_AL_OVF;
        end
        S_AL_OVF: begin
          if (sum > 34'h1_0000_0000) begin
            res_q.status <= ST_OVERFLOW;
          end else begin
            res_q.alloc_start <= start_q[31:0];
            used              <= used + 1'b1;
          end
          state <= S_DONE;
        end
        S_CK_BASE: begin
          if (base_hit) begin
            res_q.is_valid <= 1'b1;
            state          <= S_DONE;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Test the entry read last cycle, else issue the next read
          if (pend && cmd_q == CMD_RELEASE && eq_hit) begin
            res_q.freed_start <= rd_q.start;
            res_q.freed_bytes <= rd_q.len;
            dst               <= idx - 1'b1;
            pend              <= 1'b0;
            state             <= S_SHIFT;
          end else if (pend && cmd_q == CMD_CHECK && range_hit) begin
            res_q.is_valid <= 1'b1;
            pend           <= 1'b0;
            state          <= S_DONE;
          end else if (idx >= used) begin
            if (cmd_q == CMD_RELEASE) begin
              res_q.status <= ST_NOT_FOUND;
            end
            pend  <= 1'b0;
            state <= S_DONE;
          end else begin
            idx  <= idx + 1'b1;
            pend <= 1'b1;
          end
        end
        S_SHIFT: begin
          // Move later entries down one slot, one per cycle
          if (!pend && idx >= used) begin
            used  <= used - 1'b1;
            state <= S_DONE;
          end else begin
            if (pend) begin
              dst <= dst + 1'b1;
            end
            if (idx < used) begin
              idx  <= idx + 1'b1;
              pend <= 1'b1;
            end else begin
              pend <= 1'b0;
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_busy  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res       = res_q;

  // A compaction write never lands on an entry still to be read
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && wr_en) |-> (dst < idx))
    else $error("shift write overtakes read pointer");

  // An append only happens while the table has room
  assert property (@(posedge clk) disable iff (rst)
    (state == S_AL_OVF && wr_en) |-> (used < DEPTH_CNT))
    else $error("append into full table");

  // An accepted item keeps the sequencer busy
  assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state != S_IDLE))
    else $error("sequencer idle after accept");

  // The region count moves only when an allocate or release finishes
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used != $past(used)) |->
      ($past(state) == S_AL_OVF || $past(state) == S_SHIFT))
    else $error("region count changed outside finish step");

  // A result is taken only while one is offered
  assert property (@(posedge clk) disable iff (rst)
    res_take |-> (state == S_DONE))
    else $error("result taken while none offered");

endmodule

// ----- hw/rtl/virtual_region_allocator_top.sv -----
`timescale 1ns / 1ps

// Channel  Signals                          Direction  Beat when
// req      req_valid req_stall req_data     in         req_valid && !req_stall
// rsp      rsp_valid rsp_stall rsp_data     out        rsp_valid && !rsp_stall
// cfg      cfg_valid cfg_ready cfg_data     in         cfg_valid && cfg_ready
//
// Every item runs through one sequencer sharing a single adder and one read port
// of the region table. Allocate rounds the size up to whole pages, takes the start
// after the base page or after the last region, then checks for overflow; a full
// table ends it after the rounding step. Release scans the regions in use in order
// and, on a hit, moves each later entry down one slot. Check tests the base page,
// then scans the table until a region holds the address.
// Reset is synchronous: the region count and pool_base clear, table contents are
// left as they are. A stalled result sits in the output register while the next
// item is taken.

module virtual_region_allocator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  vra_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output vra_pkg::rsp_t rsp_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);
  import vra_pkg::*;

  logic [31:0] pool_base;
  logic        req_busy;
  logic        req_fire;
  logic        res_valid;
  logic        res_take;
  rsp_t        res;

  // Pool base register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pool_base <= cfg_data;
    end
  end

  assign req_stall = req_busy;
  assign req_fire  = req_valid && !req_busy;

  vra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pool_base (pool_base),
    .req_fire  (req_fire),
    .req       (req_data),
    .req_busy  (req_busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: load when empty or draining this cycle
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp_data <= res;
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import vra_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int PHASE_GAP   = 20;
  localparam int TAIL_CYCLES = 1100;
  localparam int IDLE_PCT    = 11;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_data  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  // Commands waiting to be driven and outcomes waiting to come back
  req_t cmd_backlog[$];
  rsp_t outcome_due[$];

  // Shadow of the region table and the pool base
  logic [31:0] tbl_start [TABLE_DEPTH];
  logic [31:0] tbl_len   [TABLE_DEPTH];
  int          tbl_used    = 0;
  logic [31:0] pool_base_q = '0;

  bit calm     = 1'b0;
  bit req_beat = 1'b0;
  int fails    = 0;
  int quiet    = 0;

  virtual_region_allocator_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow table and return its outcome
  function automatic rsp_t predict_outcome(input req_t r);
    rsp_t        o;
    logic [63:0] pages, bytes, start, a;
    int          hit;
    o   = '0;
    hit = -1;
    a   = {32'd0, r.query_addr};
    case (r.cmd)
      CMD_ALLOC: begin
        pages = ({32'd0, r.request_bytes} + 64'(PAGE_BYTES - 1)) / 64'(PAGE_BYTES);
        if (pages == 0) pages = 1;
        bytes = pages * 64'(PAGE_BYTES);
        if (tbl_used == 0) start = {32'd0, pool_base_q} + 64'(PAGE_BYTES);
        else start = {32'd0, tbl_start[tbl_used-1]} + {32'd0, tbl_len[tbl_used-1]};
        if (tbl_used >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else if (start + bytes > 64'h1_0000_0000) begin
          o.status = ST_OVERFLOW;
        end else begin
          tbl_start[tbl_used] = start[31:0];
          tbl_len[tbl_used]   = bytes[31:0];
          tbl_used++;
          o.alloc_start = start[31:0];
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < tbl_used; i++)
          if (hit < 0 && tbl_start[i] == r.query_addr) hit = i;
        if (hit < 0) begin
          o.status = ST_NOT_FOUND;
        end else begin
          o.freed_start = tbl_start[hit];
          o.freed_bytes = tbl_len[hit];
          // compact the later entries down by one
          for (int j = hit; j + 1 < tbl_used; j++) begin
            tbl_start[j] = tbl_start[j+1];
            tbl_len[j]   = tbl_len[j+1];
          end
          tbl_used--;
        end
      end
      CMD_CHECK: begin
        if (a >= {32'd0, pool_base_q} && a < {32'd0, pool_base_q} + 64'(PAGE_BYTES))
          o.is_valid = 1'b1;
        for (int i = 0; i < tbl_used; i++)
          if (a >= {32'd0, tbl_start[i]} &&
              a < {32'd0, tbl_start[i]} + {32'd0, tbl_len[i]})
            o.is_valid = 1'b1;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t make_cmd(input logic [1:0] c, input logic [31:0] b,
                                    input logic [31:0] a);
    req_t r;
    r.cmd           = c;
    r.request_bytes = b;
    r.query_addr    = a;
    return r;
  endfunction

  // Random command, aimed mostly at live regions and the base page
  function automatic req_t pick_command();
    req_t r;
    int   k, n;
    r.request_bytes = $urandom;
    r.query_addr    = $urandom;
    n = (tbl_used == 0) ? 0 : $urandom_range(0, tbl_used - 1);
    k = $urandom_range(0, 99);
    if (k < 45) begin
      r.cmd = CMD_ALLOC;
      k = $urandom_range(0, 99);
      if (k < 70) r.request_bytes = $urandom_range(0, 3 * PAGE_BYTES);
      else if (k < 90) r.request_bytes = $urandom_range(0, 32'h000F_FFFF);
    end else if (k < 70) begin
      r.cmd = CMD_RELEASE;
      k = $urandom_range(0, 99);
      if (tbl_used != 0 && k < 75) r.query_addr = tbl_start[n];
      else if (tbl_used != 0 && k < 85)
        r.query_addr = tbl_start[n] + $urandom_range(1, PAGE_BYTES - 1);
      else if (k < 92) r.query_addr = pool_base_q;
    end else if (k < 95) begin
      r.cmd = CMD_CHECK;
      k = $urandom_range(0, 99);
      if (tbl_used != 0 && k < 45) r.query_addr = tbl_start[n] + ($urandom % tbl_len[n]);
      else if (tbl_used != 0 && k < 60) r.query_addr = tbl_start[n] + tbl_len[n];
      else if (k < 75) r.query_addr = pool_base_q + $urandom_range(0, PAGE_BYTES);
    end else begin
      r.cmd = CMD_UNUSED;
    end
    return r;
  endfunction

  // Wait for an empty backlog; strict also waits until every beat has answered
  task automatic wait_for_room(input bit strict);
    bit go;
    go = 1'b0;
    while (!go) begin
      @(posedge clk);
      #1;
      go = cmd_backlog.size() == 0 &&
           (!strict || (!req_valid && outcome_due.size() == 0));
    end
  endtask

  task automatic settle(input int gap);
    wait_for_room(1'b1);
    repeat (gap) @(posedge clk);
  endtask

  task automatic drain_table();
    wait_for_room(1'b1);
    while (tbl_used != 0) begin
      cmd_backlog.push_back(make_cmd(CMD_RELEASE, $urandom,
                                     tbl_start[$urandom_range(0, tbl_used - 1)]));
      wait_for_room(1'b1);
    end
  endtask

  task automatic write_pool_base(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    repeat (count) begin
      wait_for_room(1'b0);
      cmd_backlog.push_back(pick_command());
    end
  endtask

  // Driver: advance to the next command once the current beat is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!req_valid || req_beat) begin
        if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          req_valid <= 1'b1;
          req_data  <= cmd_backlog.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Monitor: check each result beat, predict each command beat
  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      req_beat <= 1'b0;
      quiet    <= 0;
    end else begin
      req_beat <= req_valid && !req_stall;
      if (rsp_valid && !rsp_stall) begin
        if (outcome_due.size() == 0) begin
          $error("result beat with no command outstanding");
          fails++;
        end else begin
          want = outcome_due.pop_front();
          if (rsp_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_data.status);
            fails++;
          end
          if (rsp_data.alloc_start !== want.alloc_start) begin
            $error("alloc_start: expected %h, got %h", want.alloc_start,
                   rsp_data.alloc_start);
            fails++;
          end
          if (rsp_data.is_valid !== want.is_valid) begin
            $error("is_valid: expected %0d, got %0d", want.is_valid, rsp_data.is_valid);
            fails++;
          end
          if (rsp_data.freed_start !== want.freed_start) begin
            $error("freed_start: expected %h, got %h", want.freed_start,
                   rsp_data.freed_start);
            fails++;
          end
          if (rsp_data.freed_bytes !== want.freed_bytes) begin
            $error("freed_bytes: expected %h, got %h", want.freed_bytes,
                   rsp_data.freed_bytes);
            fails++;
          end
        end
      end
      if (req_valid && !req_stall) outcome_due.push_back(predict_outcome(req_data));
      if (cfg_valid && cfg_ready) pool_base_q = cfg_data;
      // watchdog on cycles with no beat on any channel
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin : stimulus
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Base page at zero: base page bounds, rounding, exclusive end, misses
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,         32'h0));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,         32'h0000_0FFF));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,         32'h0000_1000));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'h0,         32'h0));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'h1,         32'h0));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'h1000,      32'h0));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'h1001,      32'h0));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,         32'h0000_5FFF));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,         32'h0000_6000));
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, 32'h0,         32'h0000_2000));
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, 32'h0,         32'h0000_2000));
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, 32'h0,         32'h0));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'hFFFF_FFFF, 32'h0));
    cmd_backlog.push_back(make_cmd(CMD_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,         32'hFFFF_FFFF));
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, 32'h0,         32'h0000_4000));
    drain_table();
    settle(PHASE_GAP);

    // Region ending exactly at the top of the address space, then overflow
    write_pool_base(32'hFFFF_E000);
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'h1000, 32'h0));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC,   32'h0,    32'h0));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,    32'hFFFF_FFFF));
    cmd_backlog.push_back(make_cmd(CMD_CHECK,   32'h0,    32'hFFFF_E000));
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, 32'h0,    32'hFFFF_F000));
    settle(PHASE_GAP);

    // Base page at the very top: no room for any region
    write_pool_base(32'hFFFF_FFFF);
    cmd_backlog.push_back(make_cmd(CMD_ALLOC, 32'h0, 32'h0));
    cmd_backlog.push_back(make_cmd(CMD_CHECK, 32'h0, 32'hFFFF_FFFF));
    cmd_backlog.push_back(make_cmd(CMD_CHECK, 32'h0, 32'h0));
    settle(PHASE_GAP);

    // Random phases over several pool bases
    write_pool_base($urandom_range(0, 32'h0007_FFFF) << 12);
    run_random(8);
    settle(PHASE_GAP);

    write_pool_base($urandom);
    calm = 1'b1;
    run_random(20);
    settle(PHASE_GAP);
    calm = 1'b0;

    drain_table();
    settle(PHASE_GAP);
    write_pool_base(32'hFFF0_0000);
    run_random(8);
    settle(PHASE_GAP);

    // Move the base with regions still live near the top
    write_pool_base(32'h0);
    run_random(8);
    drain_table();
    settle(PHASE_GAP);

    // Fill the table to capacity from a low base
    write_pool_base($urandom_range(1, 32'h0FFF) << 12);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wait_for_room(1'b0);
      if (tbl_used != 0 && $urandom_range(0, 99) < 3) begin
        n = $urandom_range(0, tbl_used - 1);
        cmd_backlog.push_back(make_cmd(CMD_CHECK, $urandom,
                                       tbl_start[n] + $urandom_range(0, 2 * PAGE_BYTES)));
        wait_for_room(1'b0);
      end
      cmd_backlog.push_back(make_cmd(CMD_ALLOC, $urandom_range(0, 4 * PAGE_BYTES), $urandom));
    end
    repeat (3) begin
      wait_for_room(1'b0);
      cmd_backlog.push_back(make_cmd(CMD_ALLOC, $urandom, $urandom));
    end

    // Release from the middle and the front of a full table, refill, overfill
    wait_for_room(1'b1);
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, $urandom,
                                   tbl_start[$urandom_range(1, tbl_used - 2)]));
    wait_for_room(1'b1);
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, $urandom, tbl_start[0]));
    wait_for_room(1'b1);
    n = $urandom_range(0, tbl_used - 1);
    cmd_backlog.push_back(make_cmd(CMD_CHECK, $urandom, tbl_start[n] + tbl_len[n] - 1));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC, $urandom_range(0, PAGE_BYTES), $urandom));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC, $urandom_range(0, PAGE_BYTES), $urandom));
    cmd_backlog.push_back(make_cmd(CMD_ALLOC, $urandom_range(0, PAGE_BYTES), $urandom));
    wait_for_room(1'b1);
    cmd_backlog.push_back(make_cmd(CMD_RELEASE, $urandom, tbl_start[tbl_used - 1]));
    cmd_backlog.push_back(make_cmd(CMD_CHECK, $urandom, $urandom));

    settle(TAIL_CYCLES);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/vra_pkg.sv
hw/rtl/vra_ctrl.sv
hw/rtl/virtual_region_allocator_top.sv
sim/testbench.sv
